>>> src/npc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search core.
// ---------------------------------------------------------------------------
package npc_pkg;

    localparam int CH_W      = 8;
    localparam int COLOR_W   = 24;
    localparam int DIST_W    = 18;
    localparam int COUNT_W   = 9;
    localparam int OUT_IDX_W = 8;
    localparam int NUM_CELLS = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } seq_state_t;

    // query setup handed to the best-match tracker
    typedef struct packed {
        logic              start;
        logic              empty;
        logic [DIST_W-1:0] limit;
    } srch_start_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] best_index;
        logic [DIST_W-1:0]    best_distance;
    } res_t;

endpackage
`default_nettype wire

>>> src/npc_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npc_if
// Request and result channels: valid/ready handshake with payload.
// ---------------------------------------------------------------------------
interface npc_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [8:0]  entry_count;
    logic [17:0] start_limit;

    modport source (
        output valid, op, entry_index, red, green, blue, entry_count, start_limit,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, red, green, blue, entry_count, start_limit,
        output ready
    );
endinterface

interface npc_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  best_index;
    logic [17:0] best_distance;

    modport source (
        output valid, found, best_index, best_distance,
        input  ready
    );
    modport sink (
        input  valid, found, best_index, best_distance,
        output ready
    );
endinterface
`default_nettype wire

>>> src/npc_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/npc_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npc_cell
// One channel cell: squares the difference of the leading color byte
// against its target byte, adds it to the running sum, shifts the color on.
// ---------------------------------------------------------------------------
module npc_cell #(
    parameter int IDX_W = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       tgt_load,
    input  wire logic [npc_pkg::CH_W-1:0]   tgt_in,
    input  wire logic                       in_valid,
    input  wire logic                       in_last,
    input  wire logic [IDX_W-1:0]           in_index,
    input  wire logic [npc_pkg::COLOR_W-1:0] in_color,
    input  wire logic [npc_pkg::DIST_W-1:0] in_sum,
    output logic                            out_valid,
    output logic                            out_last,
    output logic      [IDX_W-1:0]           out_index,
    output logic      [npc_pkg::COLOR_W-1:0] out_color,
    output logic      [npc_pkg::DIST_W-1:0] out_sum
);

    logic [npc_pkg::CH_W-1:0]    tgt_reg;
    logic                        valid_reg;
    logic                        last_reg;
    logic [IDX_W-1:0]            index_reg;
    logic [npc_pkg::COLOR_W-1:0] color_reg;
    logic [npc_pkg::DIST_W-1:0]  sum_reg;

    logic [npc_pkg::CH_W-1:0]    chan;
    logic [npc_pkg::CH_W-1:0]    diff;
    logic [2*npc_pkg::CH_W-1:0]  sq;
    logic [npc_pkg::DIST_W-1:0]  sum_next;
    logic [npc_pkg::COLOR_W-1:0] color_next;

    always_comb
    begin
        chan       = in_color[npc_pkg::COLOR_W-1 -: npc_pkg::CH_W];
        diff       = (chan > tgt_reg) ? (chan - tgt_reg) : (tgt_reg - chan);
        sq         = diff * diff;
        sum_next   = in_sum + npc_pkg::DIST_W'(sq);
        color_next = {in_color[npc_pkg::COLOR_W-npc_pkg::CH_W-1:0],
                      {npc_pkg::CH_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            last_reg  <= in_last & in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_load)
        begin
            tgt_reg <= tgt_in;
        end
        index_reg <= in_index;
        color_reg <= color_next;
        sum_reg   <= sum_next;
    end

    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign out_index = index_reg;
    assign out_color = color_reg;
    assign out_sum   = sum_reg;

endmodule
`default_nettype wire

>>> src/npc_best.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npc_best
// Running best-match tracker at the end of the cell chain.
// ---------------------------------------------------------------------------
module npc_best #(
    parameter int IDX_W = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire npc_pkg::srch_start_t       ctl,
    input  wire logic                       in_valid,
    input  wire logic                       in_last,
    input  wire logic [IDX_W-1:0]           in_index,
    input  wire logic [npc_pkg::DIST_W-1:0] in_sum,
    output logic                            done,
    output npc_pkg::res_t                   res
);

    logic [npc_pkg::DIST_W-1:0] limit_reg, limit_next;
    logic [IDX_W-1:0]           index_reg, index_next;
    logic                       hit_reg, hit_next;
    logic                       done_reg, done_next;
    logic [31:0]                index_wide;

    always_comb
    begin
        limit_next = limit_reg;
        index_next = index_reg;
        hit_next   = hit_reg;
        done_next  = done_reg;
        if (ctl.start)
        begin
            limit_next = ctl.limit;
            index_next = '0;
            hit_next   = 1'b0;
            done_next  = ctl.empty;
        end
        else if (in_valid)
        begin
            if (in_sum < limit_reg)
            begin
                limit_next = in_sum;
                index_next = in_index;
                hit_next   = 1'b1;
            end
            if (in_last)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
            index_reg <= '0;
        end
        else
        begin
            hit_reg   <= hit_next;
            done_reg  <= done_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
    end

    assign index_wide        = 32'(index_reg);
    assign done              = done_reg;
    assign res.found         = hit_reg;
    assign res.best_index    = index_wide[npc_pkg::OUT_IDX_W-1:0];
    assign res.best_distance = limit_reg;

endmodule
`default_nettype wire

>>> src/nearest_palette_color_search_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nearest_palette_color_search_core
// Palette store with a nearest-color query over the leading entries,
// squared RGB distance, strict less-than against a running bound.
// ---------------------------------------------------------------------------
// Load request: accepted whenever the sequencer is idle.
// Query request: registered palette reads of the first entry_count entries
//   (saturated to the palette depth), one entry per cycle, then three channel
//   cells, the tracker and the output register; a count of zero skips the reads.
// One query at a time; the next request is taken once the result is loaded
//   into the output register, while that result may still wait for ready.
// Reset clears the sequencer and valid flags; palette contents are undefined.
// ---------------------------------------------------------------------------
module nearest_palette_color_search_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    npc_req_if.sink    req,
    npc_res_if.source  res
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    npc_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_last_reg, rd_last_next;
    logic [IDX_W-1:0]    rd_index_reg;
    logic                out_valid_reg, out_valid_next;
    npc_pkg::res_t       res_reg, res_next;

    npc_pkg::srch_start_t ctl;
    npc_pkg::res_t        best_res;
    logic                 best_done;

    logic                        accept;
    logic [31:0]                 idx_wide;
    logic [31:0]                 cnt_wide;
    logic [31:0]                 cnt_sat;
    logic                        ram_we;
    logic [npc_pkg::COLOR_W-1:0] ram_rdata;
    logic [npc_pkg::COLOR_W-1:0] tgt_word;

    logic                        ch_valid [0:npc_pkg::NUM_CELLS];
    logic                        ch_last  [0:npc_pkg::NUM_CELLS];
    logic [IDX_W-1:0]            ch_index [0:npc_pkg::NUM_CELLS];
    logic [npc_pkg::COLOR_W-1:0] ch_color [0:npc_pkg::NUM_CELLS];
    logic [npc_pkg::DIST_W-1:0]  ch_sum   [0:npc_pkg::NUM_CELLS];

    assign accept   = req.valid & req.ready;
    assign idx_wide = {24'd0, req.entry_index};
    assign cnt_wide = {23'd0, req.entry_count};
    assign cnt_sat  = (cnt_wide > 32'(PALETTE_DEPTH)) ? 32'(PALETTE_DEPTH) : cnt_wide;
    assign tgt_word = {req.red, req.green, req.blue};
    assign ram_we   = accept && (req.op == npc_pkg::OP_LOAD)
                      && (idx_wide < 32'(PALETTE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rd_valid_next  = 1'b0;
        rd_last_next   = 1'b0;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        ctl            = '0;
        req.ready      = 1'b0;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            npc_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && (req.op == npc_pkg::OP_QUERY))
                begin
                    ctl.start  = 1'b1;
                    ctl.empty  = (cnt_sat == 32'd0);
                    ctl.limit  = req.start_limit;
                    count_next = cnt_sat[CNT_W-1:0];
                    scan_next  = '0;
                    state_next = (cnt_sat == 32'd0) ? npc_pkg::ST_DRAIN : npc_pkg::ST_SCAN;
                end
            end
            npc_pkg::ST_SCAN:
            begin
                rd_valid_next = 1'b1;
                rd_last_next  = (scan_reg == count_reg - CNT_W'(1));
                scan_next     = scan_reg + CNT_W'(1);
                if (rd_last_next)
                begin
                    state_next = npc_pkg::ST_DRAIN;
                end
            end
            npc_pkg::ST_DRAIN:
            begin
                if (best_done && (!out_valid_reg || res.ready))
                begin
                    res_next       = best_res;
                    out_valid_next = 1'b1;
                    state_next     = npc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npc_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_index_reg <= scan_reg[IDX_W-1:0];
        res_reg      <= res_next;
    end

    npc_ram #(
        .WIDTH (npc_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_wide[IDX_W-1:0]),
        .wdata (tgt_word),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ch_valid[0] = rd_valid_reg;
    assign ch_last[0]  = rd_last_reg;
    assign ch_index[0] = rd_index_reg;
    assign ch_color[0] = ram_rdata;
    assign ch_sum[0]   = '0;

    for (genvar k = 0; k < npc_pkg::NUM_CELLS; k++)
    begin : g_cell
        npc_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tgt_load  (ctl.start),
            .tgt_in    (tgt_word[npc_pkg::COLOR_W-1-k*npc_pkg::CH_W -: npc_pkg::CH_W]),
            .in_valid  (ch_valid[k]),
            .in_last   (ch_last[k]),
            .in_index  (ch_index[k]),
            .in_color  (ch_color[k]),
            .in_sum    (ch_sum[k]),
            .out_valid (ch_valid[k+1]),
            .out_last  (ch_last[k+1]),
            .out_index (ch_index[k+1]),
            .out_color (ch_color[k+1]),
            .out_sum   (ch_sum[k+1])
        );
    end

    npc_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_valid (ch_valid[npc_pkg::NUM_CELLS]),
        .in_last  (ch_last[npc_pkg::NUM_CELLS]),
        .in_index (ch_index[npc_pkg::NUM_CELLS]),
        .in_sum   (ch_sum[npc_pkg::NUM_CELLS]),
        .done     (best_done),
        .res      (best_res)
    );

    assign res.valid         = out_valid_reg;
    assign res.found         = res_reg.found;
    assign res.best_index    = res_reg.best_index;
    assign res.best_distance = res_reg.best_distance;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_palette_color_search_core. Load requests
// fill a shadow palette; each query request is scored against that shadow
// (squared RGB distance, strict less-than against a running bound) and the
// expected match is queued. Results are checked in order, field by field,
// under random source gaps, random sink stalls, a long sink hold-off and
// a drain pause. Queries only ever reach entries that have been written.
// ---------------------------------------------------------------------------
module tb;

    localparam int PAL_DEPTH   = 256;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 300;
    localparam logic [17:0] LIMIT_MAX = 18'h3FFFF;

    typedef struct packed {
        logic        op;
        logic [7:0]  entry_index;
        logic [23:0] rgb;
        logic [8:0]  entry_count;
        logic [17:0] start_limit;
    } palette_req_t;

    logic clk;
    logic rst_n;

    npc_req_if req_ch ();
    npc_res_if res_ch ();

    nearest_palette_color_search_core #(
        .PALETTE_DEPTH (PAL_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    logic [23:0]   palette_shadow [PAL_DEPTH];
    bit            palette_written [PAL_DEPTH];
    npc_pkg::res_t expected_matches [$];

    int mismatch_count;
    int cycle_count;
    int stall_left;
    int hold_left;
    bit src_gaps_on;
    bit sink_gaps_on;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic npc_pkg::res_t nearest_match(logic [23:0] tgt, logic [8:0] count,
                                                    logic [17:0] limit);
        npc_pkg::res_t m;
        int   n;
        int   bound;
        int   d;
        int   diff;
        m.found      = 1'b0;
        m.best_index = '0;
        bound = limit;
        n = (count > PAL_DEPTH) ? PAL_DEPTH : count;
        for (int i = 0; i < n; i++)
        begin
            d = 0;
            for (int k = 0; k < 3; k++)
            begin
                diff = int'(palette_shadow[i][8*k +: 8]) - int'(tgt[8*k +: 8]);
                d += diff * diff;
            end
            if (d < bound)
            begin
                bound        = d;
                m.found      = 1'b1;
                m.best_index = 8'(i);
            end
        end
        m.best_distance = 18'(bound);
        return m;
    endfunction

    function automatic void apply_request(palette_req_t item);
        if (item.op == npc_pkg::OP_LOAD)
        begin
            if (int'(item.entry_index) < PAL_DEPTH)
            begin
                palette_shadow[item.entry_index]  = item.rgb;
                palette_written[item.entry_index] = 1'b1;
            end
        end
        else
            expected_matches.push_back(nearest_match(item.rgb, item.entry_count,
                                                     item.start_limit));
    endfunction

    function automatic int written_prefix();
        int p;
        p = 0;
        while (p < PAL_DEPTH && palette_written[p])
            p++;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic palette_req_t make_load(logic [7:0] idx, logic [23:0] rgb);
        palette_req_t item;
        item.op          = npc_pkg::OP_LOAD;
        item.entry_index = idx;
        item.rgb         = rgb;
        item.entry_count = 9'($urandom_range(0, 511));
        item.start_limit = 18'($urandom_range(0, 262143));
        return item;
    endfunction

    function automatic palette_req_t make_query(logic [23:0] rgb, logic [8:0] count,
                                                logic [17:0] limit);
        palette_req_t item;
        item.op          = npc_pkg::OP_QUERY;
        item.entry_index = 8'($urandom_range(0, 255));
        item.rgb         = rgb;
        item.entry_count = count;
        item.start_limit = limit;
        return item;
    endfunction

    function automatic palette_req_t random_load();
        int          prefix;
        logic [7:0]  idx;
        logic [23:0] rgb;
        prefix = written_prefix();
        if (prefix < PAL_DEPTH && $urandom_range(0, 2) != 0)
            idx = 8'(prefix);
        else
            idx = 8'($urandom_range(0, PAL_DEPTH - 1));
        rgb = 24'($urandom());
        // duplicate colors make ties
        if (prefix > 0 && $urandom_range(0, 7) == 0)
            rgb = palette_shadow[$urandom_range(0, prefix - 1)];
        return make_load(idx, rgb);
    endfunction

    function automatic palette_req_t random_query();
        int          avail;
        int          sel;
        int          c;
        logic [8:0]  count;
        logic [17:0] limit;
        logic [23:0] tgt;
        avail = written_prefix();
        if (avail == PAL_DEPTH)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                count = 9'($urandom_range(0, 24));
            else if (sel < 8)
                count = 9'($urandom_range(0, 256));
            else
                count = 9'($urandom_range(256, 511));
        end
        else
            count = 9'($urandom_range(0, avail));
        tgt = 24'($urandom());
        if (avail > 0 && $urandom_range(0, 3) == 0)
        begin
            tgt = palette_shadow[$urandom_range(0, avail - 1)];
            for (int k = 0; k < 3; k++)
            begin
                c = int'(tgt[8*k +: 8]) + $urandom_range(0, 6) - 3;
                c = (c < 0) ? 0 : ((c > 255) ? 255 : c);
                tgt[8*k +: 8] = 8'(c);
            end
        end
        sel = $urandom_range(0, 9);
        if (sel < 4)
            limit = 18'($urandom_range(0, 262143));
        else if (sel < 6)
            limit = LIMIT_MAX;
        else if (sel < 8)
            limit = 18'($urandom_range(0, 3000));
        else
            limit = 18'($urandom_range(0, 16));
        return make_query(tgt, count, limit);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(input palette_req_t item);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= item.op;
        req_ch.entry_index <= item.entry_index;
        req_ch.red         <= item.rgb[23:16];
        req_ch.green       <= item.rgb[15:8];
        req_ch.blue        <= item.rgb[7:0];
        req_ch.entry_count <= item.entry_count;
        req_ch.start_limit <= item.start_limit;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_request(item);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        npc_pkg::res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            stall_left = sink_gaps_on ? $urandom_range(0, 15) : 0;
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result: found=%0d best_index=%0d best_distance=%0d",
                       res_ch.found, res_ch.best_index, res_ch.best_distance);
                mismatch_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                if (res_ch.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, res_ch.found);
                    mismatch_count++;
                end
                if (res_ch.best_index !== want.best_index)
                begin
                    $error("best_index: expected %0d, got %0d",
                           want.best_index, res_ch.best_index);
                    mismatch_count++;
                end
                if (res_ch.best_distance !== want.best_distance)
                begin
                    $error("best_distance: expected %0d, got %0d",
                           want.best_distance, res_ch.best_distance);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        send_request(make_load(8'd0, 24'h000000));
        send_request(make_load(8'd1, 24'hFFFFFF));
        send_request(make_load(8'd2, 24'h000000));
        send_request(make_load(8'd3, 24'hFF0080));
        // empty search returns the start limit
        send_request(make_query(24'h000000, 9'd0, 18'd12345));
        send_request(make_query(24'hFFFFFF, 9'd4, LIMIT_MAX));
        // tie: earliest entry wins
        send_request(make_query(24'h000000, 9'd4, LIMIT_MAX));
        send_request(make_query(24'h000000, 9'd4, 18'd0));
        // distance equal to limit is rejected
        send_request(make_query(24'hFFFFFF, 9'd1, 18'd195075));
        send_request(make_query(24'hFFFFFF, 9'd1, 18'd195076));
        send_request(make_query(24'hFF0080, 9'd4, 18'd1));
        send_request(make_query(24'h010101, 9'd3, 18'd3));
        send_request(make_query(24'h010101, 9'd3, 18'd4));
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input bit src_gaps,
                                       input bit sink_gaps);
        src_gaps_on  = src_gaps;
        sink_gaps_on = sink_gaps;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 9) < 4)
                send_request(random_load());
            else
                send_request(random_query());
        end
    endtask

    task automatic test_fill_palette();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            if (!palette_written[i])
                send_request(make_load(8'(i), 24'($urandom())));
        end
    endtask

    task automatic test_full_depth_queries();
        send_request(make_query(24'($urandom()), 9'd256, LIMIT_MAX));
        send_request(make_query(24'($urandom()), 9'd257, LIMIT_MAX));
        send_request(make_query(24'($urandom()), 9'd511, 18'($urandom_range(0, 262143))));
        send_request(make_query(24'($urandom()), 9'd384, LIMIT_MAX));
        send_request(make_query(palette_shadow[PAL_DEPTH - 1], 9'd256, LIMIT_MAX));
    endtask

    task automatic test_result_backpressure();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        hold_left    = 500;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
                send_request(random_load());
            else
                send_request(make_query(24'($urandom()), 9'($urandom_range(0, 12)),
                                        18'($urandom_range(0, 262143))));
        end
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(random_query());
        wait_results_drained();
        for (int i = 0; i < 6; i++)
            send_request(random_query());
        wait_results_drained();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = npc_pkg::OP_LOAD;
        req_ch.entry_index = '0;
        req_ch.red         = '0;
        req_ch.green       = '0;
        req_ch.blue        = '0;
        req_ch.entry_count = '0;
        req_ch.start_limit = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_traffic(100, 1'b1, 1'b1);
        test_fill_palette();
        test_full_depth_queries();
        test_result_backpressure();
        test_random_traffic(250, 1'b1, 1'b1);
        test_sender_pause();
        test_random_traffic(120, 1'b0, 1'b0);
        test_random_traffic(120, 1'b1, 1'b0);
        test_random_traffic(120, 1'b0, 1'b1);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
